>>> hdl/binary_area_centroid_defines.svh
// Assertion macros shared by the binary_area_centroid RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BINARY_AREA_CENTROID_DEFINES_SVH
`define BINARY_AREA_CENTROID_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define BCA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that must also hold during reset
`define BCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/bca_pkg.sv
// Shared types and constants for binary_area_centroid.
// No dependencies.
package bca_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int AREA_W    = 21;
  localparam int CROW_W    = 10;
  localparam int CCOL_W    = 10;
  localparam int TDATA_W   = 48;
  localparam int TUSER_W   = 1;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [PIX_W-1:0] FG_LEVEL = 8'd255;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_COL,
    S_HOLD
  } bca_state_e;

  typedef struct packed {
    logic              empty;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
    logic [AREA_W-1:0] area;
  } bca_result_t;

endpackage

>>> hdl/binary_area_centroid.sv
// Flow: a job popped from the queue runs the row quotient (S_ROW), then the column quotient
// (S_COL), then S_HOLD loads the result register; the two quotients share one divider, 1 bit/cycle.
// Throughput: one pixel word per cycle while the job queue is not full; a two-entry job queue
// absorbs frame ends, so the input stalls only when short frames arrive faster than the
// divider finishes them or the result port holds off.
// Reset: width/height return to 640/480, position and sums clear; no clearing pass.
module binary_area_centroid #(
  parameter int MAX_WIDTH  = bca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bca_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bca_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bca_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [20:0] object_area, [30:21] centroid_row, [40:31] centroid_col, rest zero
  output logic [bca_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic [bca_pkg::TUSER_W-1:0]   m_axis_tuser   // [0] empty_frame
);
  import bca_pkg::*;

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int Q_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W = CNT_W + Q_W;
  localparam int JOB_W = CNT_W + 2 * SUM_W;

  logic             push, full, pop, fifo_empty;
  logic [JOB_W-1:0] push_data, pop_data;
  bca_result_t      res;

  bca_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_data_i  (s_axis_tdata),
    .pix_ready_o (s_axis_tready),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bca_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (pop_data)
  );

  bca_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .Q_W   (Q_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_data_i  (pop_data),
    .pop_o       (pop),
    .res_ready_i (m_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res)
  );

  assign m_axis_tdata = TDATA_W'({res.ccol, res.crow, res.area});
  assign m_axis_tuser = TUSER_W'(res.empty);

endmodule

>>> hdl/bca_front.sv
// Front end: frame geometry registers, raster position and foreground sums.
// Depends on bca_pkg; pushes one job per frame into bca_fifo.
module bca_front #(
  parameter int MAX_WIDTH  = bca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bca_pkg::MAX_HEIGHT_DEF,
  parameter int CNT_W      = 21,
  parameter int SUM_W      = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bca_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          pix_valid_i,
  input  logic [bca_pkg::PIX_W-1:0]     pix_data_i,
  output logic                          pix_ready_o,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [CNT_W+2*SUM_W-1:0]      push_data_o
);
  import bca_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]  width_q, height_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  cnt_q, cnt_nx;
  logic [SUM_W-1:0]  rsum_q, rsum_nx, csum_q, csum_nx;
  logic [WDIM_W-1:0] w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              accept, fg, col_wrap, row_last, frame_done;

  // 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = WDIM_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WDIM_W'(MAX_WIDTH);
    end else begin
      w_eff = WDIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HDIM_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = HDIM_W'(height_q);
    end
  end

  assign pix_ready_o = !full_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign fg          = (pix_data_i == FG_LEVEL);
  assign col_wrap    = (WDIM_W'(col_q) + WDIM_W'(1)) >= w_eff;
  assign row_last    = (HDIM_W'(row_q) + HDIM_W'(1)) >= h_eff;
  assign frame_done  = col_wrap && row_last;

  assign cnt_nx  = cnt_q + CNT_W'(fg);
  assign rsum_nx = fg ? rsum_q + SUM_W'(row_q) : rsum_q;
  assign csum_nx = fg ? csum_q + SUM_W'(col_q) : csum_q;

  assign push_o      = accept && frame_done;
  assign push_data_o = {csum_nx, rsum_nx, cnt_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      rsum_q <= '0;
      csum_q <= '0;
    end else if (accept) begin
      if (frame_done) begin
        col_q  <= '0;
        row_q  <= '0;
        cnt_q  <= '0;
        rsum_q <= '0;
        csum_q <= '0;
      end else begin
        cnt_q  <= cnt_nx;
        rsum_q <= rsum_nx;
        csum_q <= csum_nx;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

endmodule

>>> hdl/bca_fifo.sv
// Short job queue between the front end and the divider.
// Depends on bca_pkg for its default depth and on the assertion macro header.
`include "binary_area_centroid_defines.svh"
module bca_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = bca_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BCA_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "job pushed into full queue")
  `BCA_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o, "job popped from empty queue")
  `BCA_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= CNT_W'(DEPTH), "count out of range")

endmodule

>>> hdl/bca_back.sv
// Back end: shared restoring divider for both centroid quotients, result register.
// Depends on bca_pkg and the assertion macro header; fed by bca_fifo.
`include "binary_area_centroid_defines.svh"
module bca_back #(
  parameter int CNT_W = 21,
  parameter int SUM_W = 31,
  parameter int Q_W   = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  logic [CNT_W+2*SUM_W-1:0] job_data_i,
  output logic                     pop_o,
  input  logic                     res_ready_i,
  output logic                     res_valid_o,
  output bca_pkg::bca_result_t     res_o
);
  import bca_pkg::*;

  localparam int STEP_W = $clog2(Q_W + 1);

  bca_state_e        state_q, state_d;
  logic [CNT_W-1:0]  area_q, area_d;
  logic [SUM_W-1:0]  csum_q, csum_d, rem_q, rem_d, dvs_q, dvs_d, rem_sub;
  logic [Q_W-1:0]    quo_q, quo_d, crow_q, crow_d, quo_shift;
  logic [STEP_W-1:0] step_q, step_d;
  logic              ge, load_out, out_valid_q, out_valid_d, empty;
  bca_result_t       res_q, res_d;

  // one quotient bit per cycle, divisor pre-shifted to the top quotient bit
  assign ge        = (rem_q >= dvs_q);
  assign rem_sub   = rem_q - dvs_q;
  assign quo_shift = Q_W'({quo_q, ge});
  assign empty     = (area_q == '0);

  always_comb begin
    state_d  = state_q;
    area_d   = area_q;
    csum_d   = csum_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    quo_d    = quo_q;
    crow_d   = crow_q;
    step_d   = step_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          area_d  = job_data_i[CNT_W-1:0];
          rem_d   = job_data_i[CNT_W +: SUM_W];
          csum_d  = job_data_i[CNT_W+SUM_W +: SUM_W];
          dvs_d   = SUM_W'(job_data_i[CNT_W-1:0]) << (Q_W - 1);
          quo_d   = '0;
          step_d  = STEP_W'(Q_W);
          state_d = S_ROW;
        end
      end
      S_ROW, S_COL: begin
        if (ge) begin
          rem_d = rem_sub;
        end
        dvs_d  = dvs_q >> 1;
        quo_d  = quo_shift;
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          if (state_q == S_ROW) begin
            crow_d  = quo_shift;
            rem_d   = csum_q;
            dvs_d   = SUM_W'(area_q) << (Q_W - 1);
            quo_d   = '0;
            step_d  = STEP_W'(Q_W);
            state_d = S_COL;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (!out_valid_q || res_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      res_d.area  = AREA_W'(area_q);
      res_d.empty = empty;
      res_d.crow  = empty ? '0 : CROW_W'(crow_q);
      res_d.ccol  = empty ? '0 : CCOL_W'(quo_q);
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= area_d;
    csum_q <= csum_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    crow_q <= crow_d;
    res_q  <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `BCA_ASSERT(a_no_clobber, clk_i, rst_ni, load_out |-> (!out_valid_q || res_ready_i), "pending result overwritten")
  `BCA_ASSERT(a_rem_lt_area, clk_i, rst_ni, (state_q == S_HOLD && !empty) |-> (rem_q < SUM_W'(area_q)), "column remainder not below area")
  `BCA_ASSERT(a_step_live, clk_i, rst_ni, (state_q == S_ROW || state_q == S_COL) |-> (step_q != '0), "divider running with no steps left")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for binary_area_centroid: streams pixel words, predicts
// area and centroid per frame, and checks every result word in order.
// Depends on bca_pkg and the binary_area_centroid RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bca_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PIXELS = 350;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata = '0;   // [7:0] pixel_value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;        // [20:0] area, [30:21] crow, [40:31] ccol
  logic [TUSER_W-1:0]   m_axis_tuser;        // [0] empty_frame

  binary_area_centroid u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // frame accumulator mirror
  logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int unsigned      cur_row = 0;
  int unsigned      cur_col = 0;
  longint unsigned  fg_count = 0;
  longint unsigned  row_sum = 0;
  longint unsigned  col_sum = 0;
  bca_result_t      frame_results[$];

  int unsigned err_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned rx_hold = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    bca_result_t r;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    if (pix == FG_LEVEL) begin
      fg_count++;
      row_sum += cur_row;
      col_sum += cur_col;
    end
    if (cur_col + 1 >= w) begin
      cur_col = 0;
      if (cur_row + 1 >= h) begin
        r.area = AREA_W'(fg_count);
        if (fg_count == 0) begin
          r.crow  = '0;
          r.ccol  = '0;
          r.empty = 1'b1;
        end else begin
          r.crow  = CROW_W'(row_sum / fg_count);
          r.ccol  = CCOL_W'(col_sum / fg_count);
          r.empty = 1'b0;
        end
        frame_results.push_back(r);
        cur_row  = 0;
        fg_count = 0;
        row_sum  = 0;
        col_sum  = 0;
      end else begin
        cur_row++;
      end
    end else begin
      cur_col++;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(input int unsigned fg_pct);
    if ($urandom_range(0, 99) < fg_pct) return FG_LEVEL;
    return PIX_W'($urandom_range(0, 254));
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_centroid(input bca_result_t got);
    bca_result_t want;
    if (frame_results.size() == 0) begin
      report_mismatch($sformatf("result word with none pending, area=%0d", got.area));
      return;
    end
    want = frame_results.pop_front();
    if (got.area != want.area)
      report_mismatch($sformatf("area got %0d want %0d", got.area, want.area));
    if (got.crow != want.crow)
      report_mismatch($sformatf("centroid_row got %0d want %0d", got.crow, want.crow));
    if (got.ccol != want.ccol)
      report_mismatch($sformatf("centroid_col got %0d want %0d", got.ccol, want.ccol));
    if (got.empty != want.empty)
      report_mismatch($sformatf("empty_frame got %0b want %0b", got.empty, want.empty));
  endtask

  // result side: checks accepted words, drives tready with random stall bursts
  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        check_centroid(bca_result_t'({m_axis_tuser[0], m_axis_tdata[AREA_W+CROW_W+CCOL_W-1:0]}));
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(pix);
    pixels_sent++;
  endtask

  // stop the stream, wait for every pending result, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else if (idx == REG_FRAME_HEIGHT) height_reg = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_frames(input int unsigned nframes, input int unsigned fg_pct);
    int unsigned npix;
    npix = nframes * eff_dim(width_reg, MAX_WIDTH_DEF) * eff_dim(height_reg, MAX_HEIGHT_DEF);
    repeat (npix) send_pixel(rand_pixel(fg_pct));
  endtask

  // height keeps its reset value: a one-pixel-wide frame is 480 words
  task automatic test_reset_height();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    send_pixel(FG_LEVEL);
    repeat (478) send_pixel(rand_pixel(30));
    send_pixel(FG_LEVEL);
    drain();
  endtask

  task automatic test_directed_frames();
    logic [PIX_W-1:0] pix_list[$];
    pix_list = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,  // all foreground
                 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,    // empty
                 8'd254, 8'd127, 8'd128, 8'd1,   8'd2,   8'd255,  // only the last pixel
                 8'd255, 8'd254, 8'd0,   8'd0,   8'd0,   8'd0};   // only the first pixel
    set_dims(11'd3, 11'd2);
    foreach (pix_list[i]) send_pixel(pix_list[i]);
    drain();
  endtask

  task automatic test_dim_clamp();
    set_dims(11'd0, 11'd0);               // zero acts as one: every word is a frame
    send_pixel(FG_LEVEL);
    send_pixel(8'd0);
    send_pixel(FG_LEVEL);
    drain();
    // above max must not end a row or a frame early; a later shrink closes it
    set_dims(11'd2047, 11'd1);
    repeat (5) send_pixel(rand_pixel(50));
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd2);
    send_pixel(FG_LEVEL);
    drain();
    set_dims(11'd1, 11'd2047);
    repeat (5) send_pixel(rand_pixel(50));
    drain();
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    send_pixel(FG_LEVEL);
    drain();
    // writes past the register list leave the dimensions alone
    set_dims(11'd4, 11'd2);
    write_reg(REG_SPARE_2, CFG_W'($urandom_range(0, 2047)));
    write_reg(REG_SPARE_3, CFG_W'($urandom_range(0, 2047)));
    send_frames(2, 50);
    drain();
  endtask

  // shrink width, then height, while a frame is half done
  task automatic test_midframe_resize();
    set_dims(11'd8, 11'd4);
    repeat (13) send_pixel(FG_LEVEL);     // ends at row 1, col 5
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd3);
    repeat (4) send_pixel(FG_LEVEL);      // col 5 word closes row 1, then row 2
    drain();
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    repeat (3) send_pixel(FG_LEVEL);      // row 3 lies past the new height: frame ends
    drain();
  endtask

  task automatic test_backpressure();
    set_dims(11'd2, 11'd1);
    rx_hold = 300;
    repeat (80) send_pixel(rand_pixel(50));
    drain();
  endtask

  task automatic test_random_frames(input int unsigned npix);
    int unsigned goal;
    int unsigned wv;
    int unsigned hv;
    int unsigned fg_pct;
    goal = pixels_sent + npix;
    while (pixels_sent < goal) begin
      case ($urandom_range(0, 31))
        0: begin
          wv = $urandom_range(41, 64);
          hv = $urandom_range(0, 1);
        end
        1: begin
          wv = $urandom_range(0, 1);
          hv = $urandom_range(41, 64);
        end
        2, 3, 4, 5: begin
          wv = $urandom_range(9, 40);
          hv = $urandom_range(1, 6);
        end
        default: begin
          wv = $urandom_range(0, 8);
          hv = $urandom_range(0, 8);
        end
      endcase
      case ($urandom_range(0, 5))
        0: fg_pct = 0;
        1: fg_pct = 10;
        2: fg_pct = 90;
        3: fg_pct = 100;
        default: fg_pct = 50;
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      set_dims(CFG_W'(wv), CFG_W'(hv));
      send_frames($urandom_range(1, 3), fg_pct);
      drain();
    end
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (4) begin
      set_dims(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)));
      send_frames($urandom_range(2, 4), 50);
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_height();
    test_directed_frames();
    test_dim_clamp();
    test_midframe_resize();
    test_backpressure();
    test_random_frames(RANDOM_PIXELS);
    test_no_idle();
    drain();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
